// ----- src/signed_int_to_radix_ascii_top_assert.svh -----
// Shared concurrent assertion forms for the conversion block.
// Both forms expect clk and rst_n to be visible where they are used.
`ifndef SIGNED_INT_TO_RADIX_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_ASCII_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sira_pkg.sv -----
`default_nettype none

package sira_pkg;

    localparam int VALUE_W    = 32;
    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int SUM_W      = DIGIT_W + 1;
    localparam int CHAR_W     = 8;
    localparam int NCELL      = VALUE_BITS;
    localparam int CNT_W      = $clog2(2 * VALUE_BITS);
    localparam int LEFT_W     = $clog2(VALUE_BITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;
    localparam logic [DIGIT_W-1:0] DEC_MAX     = DIGIT_W'(9);
    localparam logic [CHAR_W-1:0] DEC_DIGITS   = CHAR_W'(10);

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DOUBLE,
        CELL_RESOLVE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [RADIX_W-1:0]  radix;
    } cell_ctl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = CHAR_W'(d);
        if (d <= DEC_MAX)
        begin
            return CHAR_ZERO + wide;
        end
        return CHAR_LOWER_A + wide - DEC_DIGITS;
    endfunction

endpackage

`default_nettype wire

// ----- src/signed_int_to_radix_ascii_top.sv -----
// Channel   Beat fields                    Handshake
// input     value[31:0], radix[5:0]        in_valid / in_stall
// output    char_code[7:0], last, bad_radix out_valid / out_stall
//
// A value enters the digit cells one magnitude bit per cycle, and each cell takes the registered
// carry of the cell below it; a carry check then repeats until no cell holds a carry.
// The sign step, the skipping of leading zeros and the emission of each digit follow in turn.
// An invalid base gives its single beat after acceptance, once the output register is free.
// A new value is taken only when the previous one has been fully handed to the output
// register, and an output stall holds the block only while it has a beat to load.
// Reset clears all control state; the block keeps nothing between values.
`default_nettype none
`include "signed_int_to_radix_ascii_top_assert.svh"

module signed_int_to_radix_ascii_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [sira_pkg::VALUE_W-1:0] value,
    input  wire logic [sira_pkg::RADIX_W-1:0]  radix,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [sira_pkg::CHAR_W-1:0]        char_code,
    output logic                               last,
    output logic                               bad_radix
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_RESOLVE,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT,
        ST_BAD
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [sira_pkg::VALUE_BITS-1:0]     mag_reg;
    logic [sira_pkg::VALUE_BITS-1:0]     mag_next;
    logic                                neg_reg;
    logic                                neg_next;
    logic [sira_pkg::RADIX_W-1:0]        radix_reg;
    logic [sira_pkg::RADIX_W-1:0]        radix_next;
    logic [sira_pkg::CNT_W-1:0]          cnt_reg;
    logic [sira_pkg::CNT_W-1:0]          cnt_next;
    logic [sira_pkg::NCELL-1:0]          done_reg;
    logic [sira_pkg::NCELL-1:0]          done_next;
    logic [sira_pkg::LEFT_W-1:0]         left_reg;
    logic [sira_pkg::LEFT_W-1:0]         left_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [sira_pkg::CHAR_W-1:0]         char_reg;
    logic [sira_pkg::CHAR_W-1:0]         char_next;
    logic                                last_reg;
    logic                                last_next;
    logic                                bad_reg;
    logic                                bad_next;

    logic [sira_pkg::VALUE_BITS-1:0]     raw;
    logic                                out_free;
    logic                                cin0;
    sira_pkg::cell_ctl_t                 ctl;
    sira_pkg::cell_ctl_t                 cell_ctl [sira_pkg::NCELL];
    logic [sira_pkg::DIGIT_W-1:0]        digit_w [sira_pkg::NCELL];
    logic [sira_pkg::NCELL-1:0]          carry_w;
    logic [sira_pkg::DIGIT_W-1:0]        top_digit;

    assign raw       = value[sira_pkg::VALUE_BITS-1:0];
    assign top_digit = digit_w[sira_pkg::NCELL-1];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        ctl.op         = sira_pkg::CELL_HOLD;
        ctl.radix      = radix_reg;
        cin0           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.op    = sira_pkg::CELL_CLEAR;
                done_next = '0;
                if (in_valid)
                begin
                    radix_next = radix;
                    neg_next   = raw[sira_pkg::VALUE_BITS-1];
                    if (raw[sira_pkg::VALUE_BITS-1])
                    begin
                        mag_next = ~raw + sira_pkg::VALUE_BITS'(1);
                    end
                    else
                    begin
                        mag_next = raw;
                    end
                    cnt_next = sira_pkg::CNT_W'(2 * sira_pkg::VALUE_BITS - 2);
                    if ((radix >= sira_pkg::RADIX_MIN) && (radix <= sira_pkg::RADIX_MAX))
                    begin
                        state_next = ST_CONVERT;
                    end
                    else
                    begin
                        state_next = ST_BAD;
                    end
                end
            end
            ST_CONVERT:
            begin
                ctl.op    = sira_pkg::CELL_DOUBLE;
                cin0      = mag_reg[sira_pkg::VALUE_BITS-1];
                mag_next  = {mag_reg[sira_pkg::VALUE_BITS-2:0], 1'b0};
                cnt_next  = cnt_reg - sira_pkg::CNT_W'(1);
                done_next = {done_reg[sira_pkg::NCELL-2:0],
                             (cnt_reg < sira_pkg::CNT_W'(sira_pkg::VALUE_BITS))};
                if (cnt_reg == '0)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (|carry_w)
                begin
                    ctl.op = sira_pkg::CELL_RESOLVE;
                end
                else
                begin
                    left_next  = sira_pkg::LEFT_W'(sira_pkg::VALUE_BITS);
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = ST_SKIP;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sira_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    bad_next       = 1'b0;
                    state_next     = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (left_reg != sira_pkg::LEFT_W'(1)))
                begin
                    ctl.op    = sira_pkg::CELL_SHIFT;
                    left_next = left_reg - sira_pkg::LEFT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctl.op         = sira_pkg::CELL_SHIFT;
                    out_valid_next = 1'b1;
                    char_next      = sira_pkg::digit_char(top_digit);
                    last_next      = (left_reg == sira_pkg::LEFT_W'(1));
                    bad_next       = 1'b0;
                    left_next      = left_reg - sira_pkg::LEFT_W'(1);
                    if (left_reg == sira_pkg::LEFT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = sira_pkg::CHAR_NONE;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Each cell takes the registered carry of the cell below it, so a cell that has taken all of
    // its magnitude bits only settles carries while the cells above it finish.
    always_comb
    begin
        for (int i = 0; i < sira_pkg::NCELL; i++)
        begin
            cell_ctl[i] = ctl;
            if ((ctl.op == sira_pkg::CELL_DOUBLE) && done_reg[i])
            begin
                cell_ctl[i].op = sira_pkg::CELL_RESOLVE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            done_reg      <= '0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    for (genvar i = 0; i < sira_pkg::NCELL; i++)
    begin : g_cell
        if (i == 0)
        begin : g_low
            sira_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[i]),
                .carry_in (cin0),
                .digit_in ({sira_pkg::DIGIT_W{1'b0}}),
                .digit    (digit_w[i]),
                .carry    (carry_w[i])
            );
        end
        else
        begin : g_up
            sira_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (cell_ctl[i]),
                .carry_in (carry_w[i-1]),
                .digit_in (digit_w[i-1]),
                .digit    (digit_w[i]),
                .carry    (carry_w[i])
            );
        end
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

    `SIRA_ASSERT_NOW(a_carries_settled,
        (state_reg == ST_SKIP) || (state_reg == ST_EMIT),
        carry_w == '0, "digit cells still hold carries while emitting")
    `SIRA_ASSERT_NOW(a_digits_remain,
        (state_reg == ST_SKIP) || (state_reg == ST_EMIT),
        left_reg != '0, "digit count ran out before the last character")
    `SIRA_ASSERT_NOW(a_bad_beat_form,
        out_valid_reg && bad_reg,
        last_reg && (char_reg == sira_pkg::CHAR_NONE), "bad base beat is malformed")

endmodule

`default_nettype wire

// ----- src/sira_cell.sv -----
`default_nettype none
`include "signed_int_to_radix_ascii_top_assert.svh"

module sira_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sira_pkg::cell_ctl_t           ctl,
    input  wire logic                          carry_in,
    input  wire logic [sira_pkg::DIGIT_W-1:0]  digit_in,
    output logic      [sira_pkg::DIGIT_W-1:0]  digit,
    output logic                               carry
);

    logic [sira_pkg::DIGIT_W-1:0] digit_reg;
    logic [sira_pkg::DIGIT_W-1:0] digit_next;
    logic                         carry_reg;
    logic                         carry_next;
    logic [sira_pkg::SUM_W-1:0]   base;
    logic [sira_pkg::SUM_W-1:0]   sum;
    logic [sira_pkg::SUM_W-1:0]   radix_ext;
    logic [sira_pkg::SUM_W-1:0]   adj;
    logic                         fold;

    always_comb
    begin
        radix_ext = sira_pkg::SUM_W'(ctl.radix);
        if (ctl.op == sira_pkg::CELL_DOUBLE)
        begin
            base = {digit_reg, 1'b0};
        end
        else
        begin
            base = sira_pkg::SUM_W'(digit_reg);
        end
        sum  = base + sira_pkg::SUM_W'(carry_in);
        fold = (sum >= radix_ext);
        adj  = fold ? (sum - radix_ext) : sum;

        digit_next = digit_reg;
        carry_next = carry_reg;
        unique case (ctl.op) inside
            sira_pkg::CELL_CLEAR:
            begin
                digit_next = '0;
                carry_next = 1'b0;
            end
            sira_pkg::CELL_DOUBLE, sira_pkg::CELL_RESOLVE:
            begin
                digit_next = adj[sira_pkg::DIGIT_W-1:0];
                carry_next = fold;
            end
            sira_pkg::CELL_SHIFT:
            begin
                digit_next = digit_in;
                carry_next = 1'b0;
            end
            default:
            begin
                digit_next = digit_reg;
                carry_next = carry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            carry_reg <= 1'b0;
        end
        else
        begin
            digit_reg <= digit_next;
            carry_reg <= carry_next;
        end
    end

    assign digit = digit_reg;
    assign carry = carry_reg;

    `SIRA_ASSERT_NEXT(a_digit_below_radix,
        (ctl.op == sira_pkg::CELL_DOUBLE) || (ctl.op == sira_pkg::CELL_RESOLVE),
        digit_reg < ctl.radix, "cell digit left its base range")

endmodule

`default_nettype wire
